@@ rtl/core/checkered_sphere_pixel_shader_defines.svh @@
// Assertion macros used by the checkered sphere pixel shader color stage (csps_color).
`ifndef CHECKERED_SPHERE_PIXEL_SHADER_DEFINES_SVH
`define CHECKERED_SPHERE_PIXEL_SHADER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSPS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CSPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/csps_pkg.sv @@
// Types and constants shared by the checkered sphere pixel shader modules.
package csps_pkg;

  // Coordinate width entering the arcsine polynomial, enough for |x| < 2^17.
  localparam int XW = 18;
  // Angles wrap to 13 bits.
  localparam int ANG_W = 13;
  // Shade terms run from 0 to 256.
  localparam int SHADE_W = 9;

  // Two polynomial lanes: longitude and latitude.
  localparam int LANES = 2;
  localparam int LANE_LON = 0;
  localparam int LANE_LAT = 1;

  typedef logic signed [XW-1:0] ax_t;

  typedef struct packed {
    logic [ANG_W-1:0]   phase;
    logic               on_ball;
    logic [SHADE_W-1:0] dim;
  } side_t;

endpackage

@@ rtl/core/csps_front.sv @@
// Front end: centring, rotation, squared radius, rim shade and longitude stretch.
module csps_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [14:0]                        pixel_x,
  input  logic [14:0]                        pixel_y,
  input  logic [csps_pkg::ANG_W-1:0]         phase,
  output logic                               out_valid,
  input  logic                               out_ready,
  output csps_pkg::ax_t                      x_lon,
  output csps_pkg::ax_t                      x_lat,
  output csps_pkg::side_t                    side
);
  import csps_pkg::*;

  localparam int NST = 4;

  localparam logic [15:0] STRETCH_ROM [33] = '{
    16'd8192,  16'd8196,  16'd8208,  16'd8228,  16'd8256,  16'd8293,  16'd8339,
    16'd8395,  16'd8460,  16'd8536,  16'd8623,  16'd8723,  16'd8836,  16'd8965,
    16'd9110,  16'd9273,  16'd9459,  16'd9669,  16'd9908,  16'd10180, 16'd10494,
    16'd10856, 16'd11280, 16'd11782, 16'd12385, 16'd13123, 16'd14052, 16'd15262,
    16'd16921, 16'd19378, 16'd23541, 16'd33027, 16'd65535
  };

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: halve and centre, then rotate. Halving and subtracting 8192
  // amounts to flipping the top bit of the halved value.
  logic signed [13:0] pxc, pyc;
  logic signed [27:0] su, sv, su_q, sv_q;
  logic signed [14:0] u1, v1;
  logic [ANG_W-1:0]   ph1;

  assign pxc = {~pixel_x[14], pixel_x[13:1]};
  assign pyc = {~pixel_y[14], pixel_y[13:1]};

  always_comb begin
    su   = 28'(pxc) * 28'sd8028 + 28'(pyc) * 28'sd1627;
    sv   = 28'(pyc) * 28'sd8028 - 28'(pxc) * 28'sd1627;
    su_q = (su + (su[27] ? 28'sd8191 : 28'sd0)) >>> 13;
    sv_q = (sv + (sv[27] ? 28'sd8191 : 28'sd0)) >>> 13;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u1  <= su_q[14:0];
      v1  <= sv_q[14:0];
      ph1 <= phase;
    end
  end

  // Stage 2: squares and the interpolation products of the stretch table.
  logic signed [29:0] uu_n, vv_n;
  logic [14:0]        av;
  logic [12:0]        ac;
  logic [4:0]         idx;
  logic [7:0]         frac;
  logic [15:0]        r0, r1;
  logic [26:0]        uu2, vv2;
  logic [23:0]        p0, p1;
  logic signed [14:0] u2, v2;
  logic [ANG_W-1:0]   ph2;

  always_comb begin
    uu_n = 30'(u1) * 30'(u1);
    vv_n = 30'(v1) * 30'(v1);
    av   = v1[14] ? 15'(-v1) : 15'(v1);
    ac   = (av > 15'd8191) ? 13'h1fff : av[12:0];
    idx  = ac[12:8];
    frac = ac[7:0];
    r0   = STRETCH_ROM[{1'b0, idx}];
    r1   = STRETCH_ROM[6'({1'b0, idx}) + 6'd1];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      uu2 <= uu_n[26:0];
      vv2 <= vv_n[26:0];
      p0  <= 24'(r0) * 24'(8'd255 - frac);
      p1  <= 24'(r1) * 24'(frac);
      u2  <= u1;
      v2  <= v1;
      ph2 <= ph1;
    end
  end

  // Stage 3: squared radius and the stretch factor.
  logic [27:0]        rr3;
  logic [24:0]        psum;
  logic [15:0]        sf3;
  logic signed [14:0] u3, v3;
  logic [ANG_W-1:0]   ph3;

  assign psum = 25'(p0) + 25'(p1);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rr3 <= 28'(uu2) + 28'(vv2);
      sf3 <= psum[23:8];
      u3  <= u2;
      v3  <= v2;
      ph3 <= ph2;
    end
  end

  // Stage 4: stretched longitude coordinate, inside test and rim shade.
  logic signed [31:0] us, us_q;
  logic [13:0]        rs;
  logic [SHADE_W-1:0] dim_n;
  logic               inside_n;

  always_comb begin
    us       = 32'(u3) * $signed(32'(sf3));
    us_q     = (us + (us[31] ? 32'sd8191 : 32'sd0)) >>> 13;
    rs       = rr3[27:14];
    inside_n = rr3 <= 28'd67108864;
    // The shade falls off linearly over the outermost 256 steps of rr/16384.
    dim_n    = (rs > 14'd3840) ? 9'(14'd4096 - rs) : 9'd256;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x_lon        <= us_q[XW-1:0];
      x_lat        <= XW'(v3);
      side.phase   <= ph3;
      side.on_ball <= inside_n;
      side.dim     <= dim_n;
    end
  end

endmodule

@@ rtl/core/csps_asin.sv @@
// Pipelined cubic/quintic arcsine polynomial, one lane each for longitude and latitude.
module csps_asin (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  csps_pkg::ax_t              x_in [csps_pkg::LANES],
  input  csps_pkg::side_t            side_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [csps_pkg::ANG_W-1:0] poly [csps_pkg::LANES],
  output csps_pkg::side_t            side_out
);
  import csps_pkg::*;

  localparam int NST = 8;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  side_t          side_q [NST];

  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];
  assign side_out  = side_q[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_q[0] <= side_in;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [21:0] t11, t11_q;
    logic signed [XW-1:0] s1, s2r;
    logic signed [35:0] sq_n;
    logic [34:0]        sq2;
    logic [21:0]        s2v, s2_3, s2_4;
    logic signed [40:0] p3;
    logic signed [40:0] p3_q;
    logic signed [26:0] s3_4;
    logic signed [49:0] p5, p5_q;
    logic signed [37:0] t3_5, t3_6;
    logic signed [36:0] s5_6;
    logic signed [47:0] xs, xs_q;
    logic [ANG_W-1:0]   s_3, s_4, s_5, s_6, s_7;

    // Stage 1: s = 11x/8, truncated toward zero.
    always_comb begin
      t11   = 22'(x_in[i]) * 22'sd11;
      t11_q = (t11 + (t11[21] ? 22'sd7 : 22'sd0)) >>> 3;
    end

    always_ff @(posedge clk) begin
      if (en[0]) begin
        s1 <= t11_q[XW-1:0];
      end
    end

    // Stage 2: s squared.
    assign sq_n = 36'(s1) * 36'(s1);

    always_ff @(posedge clk) begin
      if (en[1]) begin
        sq2 <= sq_n[34:0];
        s2r <= s1;
      end
    end

    // Stage 3: s2 = s*s/8192 is never negative, so a shift suffices.
    assign s2v = sq2[34:13];

    always_ff @(posedge clk) begin
      if (en[2]) begin
        p3   <= 41'($signed({1'b0, s2v})) * 41'(s2r);
        s2_3 <= s2v;
        s_3  <= s2r[ANG_W-1:0];
      end
    end

    // Stage 4: s3.
    assign p3_q = (p3 + (p3[40] ? 41'sd8191 : 41'sd0)) >>> 13;

    always_ff @(posedge clk) begin
      if (en[3]) begin
        s3_4 <= p3_q[26:0];
        s2_4 <= s2_3;
        s_4  <= s_3;
      end
    end

    // Stage 5: s2*s3 for the fifth power and the cubic term.
    always_ff @(posedge clk) begin
      if (en[4]) begin
        p5   <= 50'($signed({1'b0, s2_4})) * 50'(s3_4);
        t3_5 <= 38'(s3_4) * 38'sd1365;
        s_5  <= s_4;
      end
    end

    // Stage 6: s5.
    assign p5_q = (p5 + (p5[49] ? 50'sd8191 : 50'sd0)) >>> 13;

    always_ff @(posedge clk) begin
      if (en[5]) begin
        s5_6 <= p5_q[36:0];
        t3_6 <= t3_5;
        s_6  <= s_5;
      end
    end

    // Stage 7: weighted sum of the cubic and quintic terms.
    always_ff @(posedge clk) begin
      if (en[6]) begin
        xs  <= 48'(s5_6) * 48'sd614 + 48'(t3_6);
        s_7 <= s_6;
      end
    end

    // Stage 8: scale the correction and add it to s; only 13 bits survive.
    assign xs_q = (xs + (xs[47] ? 48'sd8191 : 48'sd0)) >>> 13;

    always_ff @(posedge clk) begin
      if (en[7]) begin
        poly[i] <= xs_q[ANG_W-1:0] + s_7;
      end
    end
  end

endmodule

@@ rtl/core/csps_color.sv @@
// Checker pattern, rim darkening and RGB565 packing, ending in the output register.
`include "checkered_sphere_pixel_shader_defines.svh"

module csps_color (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [csps_pkg::ANG_W-1:0] poly_in [csps_pkg::LANES],
  input  csps_pkg::side_t            side_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       inside_res,
  output logic [15:0]                color
);
  import csps_pkg::*;

  localparam int NST = 4;

  // Soft edge of one checker cell along one axis.
  function automatic logic [SHADE_W-1:0] edge_ramp(input logic [ANG_W-1:0] a);
    logic [SHADE_W-1:0] r;
    if (a < 13'd256) begin
      r = 9'(13'd256 - a);
    end else if (a < 13'd4096) begin
      r = '0;
    end else if (a < 13'd4352) begin
      r = 9'(a - 13'd4096);
    end else begin
      r = 9'd256;
    end
    return r;
  endfunction

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: spin the longitude and shape both axes.
  logic [ANG_W-1:0]   lon;
  logic [SHADE_W-1:0] cu1, cv1, dim1, dim2, dim3;
  logic               in1, in2, in3;

  assign lon = poly_in[LANE_LON] + side_in.phase;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cu1  <= edge_ramp(lon);
      cv1  <= edge_ramp(poly_in[LANE_LAT]);
      in1  <= side_in.on_ball;
      dim1 <= side_in.dim;
    end
  end

  // Stage 2: smooth checker term, centred on 128.
  logic signed [9:0]  cu_s, cv_s;
  logic signed [19:0] cprod, cprod_q;
  logic [SHADE_W-1:0] chk2;

  always_comb begin
    cu_s    = $signed({1'b0, cu1}) - 10'sd128;
    cv_s    = $signed({1'b0, cv1}) - 10'sd128;
    cprod   = 20'(cu_s) * 20'(cv_s);
    cprod_q = (cprod + (cprod[19] ? 20'sd127 : 20'sd0)) >>> 7;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      chk2 <= 9'(cprod_q + 20'sd128);
      in2  <= in1;
      dim2 <= dim1;
    end
  end

  // Stage 3: green and blue from the checker term; red stays at full scale.
  logic [13:0] gm;
  logic [12:0] bm;
  logic [5:0]  g3;
  logic [4:0]  b3;

  always_comb begin
    gm = 14'(chk2) * 14'd63;
    bm = 13'(chk2) * 13'd31;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      g3   <= gm[13:8];
      b3   <= bm[12:8];
      in3  <= in2;
      dim3 <= dim2;
    end
  end

  // Stage 4: rim darkening and packing into the output register.
  logic [12:0] rm, bm4;
  logic [13:0] gm4;

  always_comb begin
    rm  = 13'(dim3) * 13'd31;
    gm4 = 14'(g3) * 14'(dim3);
    bm4 = 13'(b3) * 13'(dim3);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      inside_res <= in3;
      color      <= in3 ? {rm[12:8], gm4[13:8], bm4[12:8]} : 16'h0000;
    end
  end

  `CSPS_ASSERT_IMPL(a_bg_black, clk, rst, out_valid && !inside_res, color == 16'h0000, "background item carries a nonzero color")
  `CSPS_ASSERT_IMPL(a_ramp_range, clk, rst, vld[0], (cu1 <= 9'd256) && (cv1 <= 9'd256), "checker ramp out of range")
  `CSPS_ASSERT_IMPL(a_chk_range, clk, rst, vld[1], chk2 <= 9'd256, "checker term out of range")
  `CSPS_ASSERT_NEXT(a_handoff, clk, rst, vld[2] && en[3], vld[3], "item lost between shade stages")

endmodule

@@ rtl/core/checkered_sphere_pixel_shader.sv @@
// Checkered sphere pixel shader top level: one stream item in, one colored pixel out.
// Each accepted item is a sample coordinate pair and a spin phase; each result item says
// whether the sample falls on the ball (tuser) and gives its RGB565 color (tdata, zero for
// background). The block is a 16-stage pipeline with no state between pixels: it takes one
// item per clock while the output side is ready. Every stage has its own valid bit and load
// enable, so a stalled output lets empty stages upstream keep filling. The deepest stage
// logic is the 23 x 27-bit multiply of the fifth-power term in the arcsine polynomial.
module checkered_sphere_pixel_shader (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // pixel_x [14:0], pixel_y [29:15], phase [42:30], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // color [15:0]
  output logic        m_axis_tuser    // inside_res [0]
);
  import csps_pkg::*;

  logic             fr_valid, fr_ready;
  ax_t              x_lon, x_lat;
  ax_t              x_ab [LANES];
  side_t            fr_side;
  logic             ab_valid, ab_ready;
  logic [ANG_W-1:0] ab_poly [LANES];
  side_t            ab_side;

  csps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .pixel_x   (s_axis_tdata[14:0]),
    .pixel_y   (s_axis_tdata[29:15]),
    .phase     (s_axis_tdata[42:30]),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .x_lon     (x_lon),
    .x_lat     (x_lat),
    .side      (fr_side)
  );

  assign x_ab[LANE_LON] = x_lon;
  assign x_ab[LANE_LAT] = x_lat;

  csps_asin u_asin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .x_in      (x_ab),
    .side_in   (fr_side),
    .out_valid (ab_valid),
    .out_ready (ab_ready),
    .poly      (ab_poly),
    .side_out  (ab_side)
  );

  csps_color u_color (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (ab_valid),
    .in_ready   (ab_ready),
    .poly_in    (ab_poly),
    .side_in    (ab_side),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .inside_res (m_axis_tuser),
    .color      (m_axis_tdata)
  );

endmodule
